// ===== src/svm_pkg.sv =====
// Shared types and constants for the sphere voxel mask painter.
// Used by the controller, the datapath, the top level and the checker.
package svm_pkg;

  // Grid and store sizes.
  localparam int MAX_DIM     = 64;
  localparam int STORE_DEPTH = 32768;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int DIM_W       = $clog2(MAX_DIM + 1);
  localparam int IDX_W       = $clog2(MAX_DIM);
  localparam int BIT_W       = 3 * IDX_W;
  localparam int NYNZ_W      = 2 * IDX_W + 1;

  // Field widths.
  localparam int COORD_W = 24;
  localparam int RAD_W   = 12;
  localparam int SPC_W   = 12;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  // Offsets, positions and comparison widths.
  localparam int DIFF_W = COORD_W + 1;
  localparam int POS_W  = IDX_W + SPC_W + 1;
  localparam int CMP_W  = DIFF_W + 2;
  localparam int DLT_W  = RAD_W + 1;
  localparam int SQ_W   = 2 * RAD_W;
  localparam int SUM_W  = SQ_W + 2;

  // Action codes.
  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_PAINT = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_POINTS_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_POINTS_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_POINTS_Z = 3'd6;

  // Request and result payloads.
  typedef struct packed {
    logic [1:0]                action;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic [RAD_W-1:0]          radius;
    logic [ADDR_W-1:0]         byte_index;
  } req_t;

  typedef struct packed {
    logic [1:0] done_action;
    logic [7:0] mask_byte;
  } res_t;

  // Grid configuration as held by the register file.
  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic [SPC_W-1:0]          spacing;
    logic [DIM_W-1:0]          points_x;
    logic [DIM_W-1:0]          points_y;
    logic [DIM_W-1:0]          points_z;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic clr_step;
    logic scan_step;
    logic box_init;
    logic pt_step;
    logic wr_bit;
    logic capture;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic scan_last;
    logic box_empty;
    logic hit;
    logic pt_last;
  } sts_t;

endpackage

// ===== src/svm_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Standalone; no package dependency.
module svm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/svm_ctrl.sv =====
// Controller state machine of the sphere voxel mask painter.
// Depends on svm_pkg for the command, status and action types.
module svm_ctrl
  import svm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] action_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o,
  output logic       busy_o,
  output logic       done_o
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLEAR, S_SCAN, S_BOX, S_SQ, S_TEST, S_RMW, S_READ, S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    case (state_q)
      S_INIT: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          case (action_i)
            ACT_CLEAR: state_d = S_CLEAR;
            ACT_PAINT: state_d = S_SCAN;
            ACT_READ:  state_d = S_READ;
            default:   state_d = S_FINISH;
          endcase
        end
      end
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_FINISH;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) state_d = S_BOX;
      end
      S_BOX: begin
        if (sts_i.box_empty) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.box_init = 1'b1;
          state_d = S_SQ;
        end
      end
      S_SQ: state_d = S_TEST;
      S_TEST: begin
        if (sts_i.hit) begin
          state_d = S_RMW;
        end else begin
          cmd_o.pt_step = 1'b1;
          state_d = sts_i.pt_last ? S_FINISH : S_SQ;
        end
      end
      S_RMW: begin
        cmd_o.wr_bit  = 1'b1;
        cmd_o.pt_step = 1'b1;
        state_d = sts_i.pt_last ? S_FINISH : S_SQ;
      end
      S_READ: state_d = S_FINISH;
      S_FINISH: begin
        cmd_o.capture = 1'b1;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

// ===== src/svm_datapath.sv =====
// Datapath of the sphere voxel mask painter: box scan, point walk,
// distance test and mask store access. Depends on svm_pkg and svm_ram.
module svm_datapath
  import svm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  input  cfg_t cfg_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output res_t res_o
);

  // Latched request and derived grid values.
  logic [1:0]                act_q;
  logic [ADDR_W-1:0]         bidx_q;
  logic [RAD_W-1:0]          rad_q;
  logic [SQ_W-1:0]           r2_q;
  logic [SPC_W-1:0]          spc_q;
  logic signed [DIFF_W-1:0]  d_q   [3];
  logic [DIM_W-1:0]          n_q   [3];
  logic [BIT_W-1:0]          w_q   [3];

  // Box scan state.
  logic [IDX_W-1:0]  k_q;
  logic [POS_W-1:0]  pk_q;
  logic [BIT_W-1:0]  kb_q   [3];
  logic [IDX_W-1:0]  lo_q   [3];
  logic [IDX_W-1:0]  hi_q   [3];
  logic [POS_W-1:0]  lo_p_q [3];
  logic [BIT_W-1:0]  lo_b_q [3];
  logic [2:0]        lo_ok_q, hi_ok_q;

  // Point walk state.
  logic [IDX_W-1:0]  i_q [3];
  logic [POS_W-1:0]  p_q [3];
  logic [BIT_W-1:0]  b_q [3];
  logic [SQ_W-1:0]   sq_q [3];

  // Clearing counter and result.
  logic [ADDR_W-1:0] clr_q;
  logic [7:0]        mbyte_q;

  logic [DIM_W-1:0]  dim_in [3];
  logic [2:0]        last;
  logic [2:0]        lo_hit, hi_hit;
  logic [BIT_W-1:0]  bit_idx;
  logic [SUM_W-1:0]  dist2;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  // A point count of zero means one point, above the limit means the limit.
  function automatic logic [DIM_W-1:0] dim_of(input logic [DIM_W-1:0] p);
    if (p == '0) return DIM_W'(1);
    if (p > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
    return p;
  endfunction

  assign dim_in[0] = dim_of(cfg_i.points_x);
  assign dim_in[1] = dim_of(cfg_i.points_y);
  assign dim_in[2] = dim_of(cfg_i.points_z);

  // Scan compares: an index may hold sphere points only if its position lies
  // strictly between center minus radius and center plus radius.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [CMP_W-1:0] pe, dm, dp;
      logic                    in_grid;
      pe = $signed({{(CMP_W-POS_W){1'b0}}, pk_q});
      dm = CMP_W'(d_q[a]) - $signed({{(CMP_W-RAD_W){1'b0}}, rad_q});
      dp = CMP_W'(d_q[a]) + $signed({{(CMP_W-RAD_W){1'b0}}, rad_q});
      in_grid = ({1'b0, k_q} < n_q[a]);
      lo_hit[a] = in_grid && !lo_ok_q[a] && (pe > dm);
      hi_hit[a] = in_grid && (pe < dp);
    end
  end

  // Walk bookkeeping: z is innermost.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      last[a] = (i_q[a] == hi_q[a]);
    end
  end

  assign bit_idx = b_q[0] + b_q[1] + b_q[2];
  assign dist2   = SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);

  assign sts_o.clr_last  = (clr_q == ADDR_W'(STORE_DEPTH - 1));
  assign sts_o.scan_last = (k_q == IDX_W'(MAX_DIM - 1));
  assign sts_o.box_empty = !(&lo_ok_q && &hi_ok_q && (lo_q[0] <= hi_q[0]) &&
                             (lo_q[1] <= hi_q[1]) && (lo_q[2] <= hi_q[2]));
  assign sts_o.hit       = (dist2 < SUM_W'(r2_q));
  assign sts_o.pt_last   = &last;

  // Request latch.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q  <= req_i.action;
      bidx_q <= req_i.byte_index;
      rad_q  <= req_i.radius;
      r2_q   <= SQ_W'(req_i.radius) * SQ_W'(req_i.radius);
      spc_q  <= (cfg_i.spacing == '0) ? SPC_W'(1) : cfg_i.spacing;
      d_q[0] <= DIFF_W'(req_i.center_x) - DIFF_W'(cfg_i.origin_x);
      d_q[1] <= DIFF_W'(req_i.center_y) - DIFF_W'(cfg_i.origin_y);
      d_q[2] <= DIFF_W'(req_i.center_z) - DIFF_W'(cfg_i.origin_z);
      for (int a = 0; a < 3; a++) begin
        n_q[a] <= dim_in[a];
      end
      w_q[0] <= BIT_W'(NYNZ_W'(dim_in[1]) * NYNZ_W'(dim_in[2]));
      w_q[1] <= BIT_W'(dim_in[2]);
      w_q[2] <= BIT_W'(1);
    end
  end

  // Box scan: one candidate index per cycle on all three axes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= '0;
      pk_q    <= '0;
      lo_ok_q <= '0;
      hi_ok_q <= '0;
      for (int a = 0; a < 3; a++) begin
        kb_q[a] <= '0;
      end
    end else if (cmd_i.latch) begin
      k_q     <= '0;
      pk_q    <= '0;
      lo_ok_q <= '0;
      hi_ok_q <= '0;
      for (int a = 0; a < 3; a++) begin
        kb_q[a] <= '0;
      end
    end else if (cmd_i.scan_step) begin
      k_q  <= k_q + IDX_W'(1);
      pk_q <= pk_q + POS_W'(spc_q);
      for (int a = 0; a < 3; a++) begin
        kb_q[a] <= kb_q[a] + w_q[a];
        if (lo_hit[a]) lo_ok_q[a] <= 1'b1;
        if (hi_hit[a]) hi_ok_q[a] <= 1'b1;
      end
    end
  end

  // Box bounds.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step) begin
      for (int a = 0; a < 3; a++) begin
        if (lo_hit[a]) begin
          lo_q[a]   <= k_q;
          lo_p_q[a] <= pk_q;
          lo_b_q[a] <= kb_q[a];
        end
        if (hi_hit[a]) hi_q[a] <= k_q;
      end
    end
  end

  // Point walk through the box.
  always_ff @(posedge clk_i) begin
    if (cmd_i.box_init) begin
      for (int a = 0; a < 3; a++) begin
        i_q[a] <= lo_q[a];
        p_q[a] <= lo_p_q[a];
        b_q[a] <= lo_b_q[a];
      end
    end else if (cmd_i.pt_step) begin
      for (int a = 0; a < 3; a++) begin
        logic carry;
        carry = 1'b1;
        for (int c = a + 1; c < 3; c++) begin
          carry = carry & last[c];
        end
        if (carry) begin
          if (last[a]) begin
            i_q[a] <= lo_q[a];
            p_q[a] <= lo_p_q[a];
            b_q[a] <= lo_b_q[a];
          end else begin
            i_q[a] <= i_q[a] + IDX_W'(1);
            p_q[a] <= p_q[a] + POS_W'(spc_q);
            b_q[a] <= b_q[a] + w_q[a];
          end
        end
      end
    end
  end

  // Squared axis offsets; inside the box every offset is below the radius.
  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      logic signed [CMP_W-1:0] dlt;
      logic signed [DLT_W-1:0] dn;
      logic signed [2*DLT_W-1:0] prod;
      dlt = $signed({{(CMP_W-POS_W){1'b0}}, p_q[a]}) - CMP_W'(d_q[a]);
      dn   = dlt[DLT_W-1:0];
      prod = dn * dn;
      sq_q[a] <= prod[SQ_W-1:0];
    end
  end

  // Clearing counter, running after reset and for a clear request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.latch) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + ADDR_W'(1);
    end
  end

  // Mask store access.
  assign ram_we    = cmd_i.clr_step || cmd_i.wr_bit;
  assign ram_waddr = cmd_i.clr_step ? clr_q : bit_idx[BIT_W-1:3];
  assign ram_wdata = cmd_i.clr_step ? 8'h00 : (ram_rdata | (8'h01 << bit_idx[2:0]));
  assign ram_raddr = (act_q == ACT_READ) ? bidx_q : bit_idx[BIT_W-1:3];

  svm_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_mask_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mbyte_q <= (act_q == ACT_READ) ? ram_rdata : 8'h00;
    end
  end

  assign res_o.done_action = act_q;
  assign res_o.mask_byte   = mbyte_q;

endmodule

// ===== src/sphere_voxel_mask_painter_top.sv =====
// Top level of the sphere voxel mask painter: configuration registers,
// controller and datapath. Depends on svm_pkg, svm_ctrl and svm_datapath.
//
// A request is taken when start_i is high and busy_o is low; its result is
// shown for one cycle with done_o and cannot be held off. After reset the
// mask store (32768 bytes) is cleared one byte a cycle, with busy_o high
// until the whole store is clear. A clear request clears it the same way,
// a read fetches the addressed byte and an unused action only closes.
// A paint scans every candidate index for the bounding box (one candidate
// index per cycle, all axes together), checks the box, squares and tests
// each grid point in the box, and does a read-modify-write of one mask
// byte for each point inside the sphere; it ends like an unused action,
// and a sphere that misses the grid goes there straight after the box check.
// Configuration writes are always taken.
module sphere_voxel_mask_painter_top
  import svm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  req_t                 req_i,
  output logic                 done_o,
  output res_t                 result_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;
  logic busy;

  assign cfg_ready_o = 1'b1;

  // Configuration register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x <= '0;
      cfg_q.origin_y <= '0;
      cfg_q.origin_z <= '0;
      cfg_q.spacing  <= SPC_W'(256);
      cfg_q.points_x <= DIM_W'(MAX_DIM);
      cfg_q.points_y <= DIM_W'(MAX_DIM);
      cfg_q.points_z <= DIM_W'(MAX_DIM);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ORIGIN_X: cfg_q.origin_x <= cfg_data_i;
        CFG_ORIGIN_Y: cfg_q.origin_y <= cfg_data_i;
        CFG_ORIGIN_Z: cfg_q.origin_z <= cfg_data_i;
        CFG_SPACING:  cfg_q.spacing  <= cfg_data_i[SPC_W-1:0];
        CFG_POINTS_X: cfg_q.points_x <= cfg_data_i[DIM_W-1:0];
        CFG_POINTS_Y: cfg_q.points_y <= cfg_data_i[DIM_W-1:0];
        CFG_POINTS_Z: cfg_q.points_z <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Controller.
  svm_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .action_i (req_i.action),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  // Datapath.
  svm_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cfg_i  (cfg_q),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .res_o  (result_o)
  );

  assign busy_o = busy;

endmodule

// ===== src/svm_checker.sv =====
// Port-level checker for the sphere voxel mask painter, bound to the top.
// Depends on svm_pkg for the payload types and action codes.
module svm_checker
  import svm_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o,
  input res_t result_o,
  input logic cfg_ready_o
);

  // A result is given only once the block has gone idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy_o)
    else $error("result strobe while busy");

  // An accepted request always makes the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (start_i && !busy_o) |=> busy_o)
    else $error("request accepted without going busy");

  // Results never come in adjacent cycles.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  // Only a read returns a nonzero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (done_o && (result_o.done_action != ACT_READ))
                   |-> (result_o.mask_byte == 8'h00))
    else $error("nonzero byte for a request other than a read");

  // Configuration writes are never refused.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind sphere_voxel_mask_painter_top svm_checker u_svm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .done_o      (done_o),
  .result_o    (result_o),
  .cfg_ready_o (cfg_ready_o)
);
